// ===== hdl/attpkt_pkg.sv =====
package attpkt_pkg;

    // Event kinds on the action field
    localparam logic [1:0] ACT_GYRO  = 2'd0;
    localparam logic [1:0] ACT_ACCEL = 2'd1;
    localparam logic [1:0] ACT_ROTV  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_PERIOD     = 3'd0;
    localparam logic [2:0] REG_MAX_AGE    = 3'd1;
    localparam logic [2:0] REG_MIN_SPEED  = 3'd2;
    localparam logic [2:0] REG_FULL_SCALE = 3'd3;
    localparam logic [2:0] REG_GAIN_MIN   = 3'd4;
    localparam logic [2:0] REG_GAIN_MAX   = 3'd5;
    localparam logic [2:0] REG_DEADBAND   = 3'd6;

    // Angles in 1/128 degree
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;

    // rad/s Q9 to 1/128 deg/s, scaled by 2^16
    localparam int GYRO_SCALE = 938734;

    localparam int CORDIC_MAX = 24;

    // atan(2^-i) in 2^-20 degree
    localparam logic [26:0] ATAN_TAB [CORDIC_MAX] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
        27'd1876857, 27'd938658, 27'd469357, 27'd234682, 27'd117342,
        27'd58671, 27'd29335, 27'd14668, 27'd7334, 27'd3667, 27'd1833,
        27'd917, 27'd458, 27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7
    };

    // Shift right by s with rounding half away from zero
    function automatic logic signed [39:0] rnd_shift(input logic signed [39:0] v,
                                                     input int s);
        logic [39:0] mag;
        logic [39:0] r;
        mag = v[39] ? 40'(-v) : 40'(v);
        r   = (mag + (40'd1 << (s - 1))) >> s;
        return v[39] ? $signed(40'(-r)) : $signed(r);
    endfunction

endpackage

// ===== hdl/attpkt_in_if.sv =====
interface attpkt_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic signed [15:0] val_x;
    logic signed [15:0] val_y;
    logic signed [15:0] val_z;
    logic signed [15:0] quat_w;
    logic        [1:0]  accuracy;
    logic        [31:0] now_ms;
    logic               gps_fix_valid;
    logic        [31:0] gps_fix_time_ms;
    logic        [15:0] gps_speed;
    logic        [15:0] gps_course;

    modport source (output valid, action, val_x, val_y, val_z, quat_w, accuracy, now_ms,
                    gps_fix_valid, gps_fix_time_ms, gps_speed, gps_course,
                    input ready);
    modport sink (input valid, action, val_x, val_y, val_z, quat_w, accuracy, now_ms,
                  gps_fix_valid, gps_fix_time_ms, gps_speed, gps_course,
                  output ready);
endinterface

// ===== hdl/attpkt_out_if.sv =====
interface attpkt_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic        [15:0] yaw;
    logic signed [19:0] gyro_x;
    logic signed [19:0] gyro_y;
    logic signed [19:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [1:0]  accuracy_out;
    logic        [31:0] stamp_ms;

    modport source (output valid, roll, pitch, yaw, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, accuracy_out, stamp_ms,
                    input ready);
    modport sink (input valid, roll, pitch, yaw, gyro_x, gyro_y, gyro_z,
                  accel_x, accel_y, accel_z, accuracy_out, stamp_ms,
                  output ready);
endinterface

// ===== hdl/attitude_packet_builder.sv =====
// Attitude packet builder. Gyro events scale three rates in turn on one shared
// multiplier; accelerometer events and rotation vectors that are not yet due
// are taken in the idle state. A due rotation vector runs the quaternion
// products on the shared multiplier, the three partial products of the pitch
// term square, the bit-pair square root, three passes of one CORDIC stage at
// one iteration per cycle, the GPS check and the load of the packet. When the
// GPS heading is valid, a restoring divider for the speed gain and the gain
// clamp come before the load, and a gain multiply and a yaw correction come
// after the clamp when the heading error is past the deadband.
// The packet sits in an output register, so the next event is taken while it
// waits for its transfer; a new packet that finds the previous one still
// waiting holds in its last cycle until the output register frees.
module attitude_packet_builder
    import attpkt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic         clk,
    input  logic         rst_n,
    attpkt_in_if.sink    in_ch,
    attpkt_out_if.source out_ch,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [15:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_GYRO, S_PROD, S_SQ, S_SQRT, S_CINIT, S_CITER, S_CDONE,
        S_GPS, S_DIV, S_GAIN, S_CMUL, S_CORR, S_DONE
    } state_t;

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic [1:0] sel_reg;
    logic       out_valid_reg;

    // Configuration
    logic [15:0] period_reg, max_age_reg, min_speed_reg, full_scale_reg;
    logic [15:0] gain_min_reg, gain_max_reg;
    logic [14:0] deadband_reg;

    // Caches
    logic signed [19:0] gyro_reg [3];
    logic signed [15:0] accel_reg [3];
    logic        [31:0] last_reg;

    // Latched event
    logic signed [15:0] vx_reg, vy_reg, vz_reg, w_reg;
    logic        [1:0]  acc_reg;
    logic        [31:0] now_reg, fixt_reg;
    logic               fixv_reg;
    logic        [15:0] spd_reg, crs_reg;

    // Datapath
    logic signed [38:0] prod_reg;
    logic signed [33:0] ry_reg, rx_reg, ps_reg, yy_reg, yx_reg;
    logic        [57:0] sq_reg;
    logic        [56:0] sqv_reg;
    logic        [57:0] sqr_reg, sqb_reg;
    logic signed [39:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic signed [15:0] roll_reg;
    logic signed [14:0] pitch_reg;
    logic        [15:0] yaw_reg;
    logic signed [17:0] err_reg;
    logic        [16:0] rem_reg;
    logic        [31:0] quo_reg, dvd_reg;
    logic        [15:0] gain_reg;

    // Output register
    logic signed [15:0] o_roll_reg;
    logic signed [14:0] o_pitch_reg;
    logic        [15:0] o_yaw_reg;
    logic signed [19:0] o_gyro_reg [3];
    logic signed [15:0] o_accel_reg [3];
    logic        [1:0]  o_acc_reg;
    logic        [31:0] o_stamp_reg;

    logic in_fire, out_free, due, gps_ok, past_db;
    logic [1:0] kd;
    logic signed [17:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [38:0] mul_p;
    logic signed [34:0] ps2;
    logic signed [29:0] s_c;
    logic        [29:0] s_abs;
    logic signed [39:0] cy_in, cx_in, zr, corr;
    logic        [58:0] rb;
    logic        [17:0] rem2;
    logic        [16:0] course;
    logic signed [17:0] e0, e1, ys;
    logic        [39:0] cidx;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign due         = (32'(in_ch.now_ms - last_reg) >= {16'd0, period_reg});
    assign kd          = 2'(cnt_reg - 6'd1);
    assign cidx        = 40'(cnt_reg);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GYRO:
            begin
                case (cnt_reg)
                    6'd0:    mul_a = 18'(vx_reg);
                    6'd1:    mul_a = 18'(vy_reg);
                    default: mul_a = 18'(vz_reg);
                endcase
                mul_b = 21'(GYRO_SCALE);
            end
            S_PROD:
            begin
                case (cnt_reg)
                    6'd0:    begin mul_a = 18'(w_reg);  mul_b = 21'(vx_reg); end
                    6'd1:    begin mul_a = 18'(vy_reg); mul_b = 21'(vz_reg); end
                    6'd2:    begin mul_a = 18'(vx_reg); mul_b = 21'(vx_reg); end
                    6'd3:    begin mul_a = 18'(vy_reg); mul_b = 21'(vy_reg); end
                    6'd4:    begin mul_a = 18'(w_reg);  mul_b = 21'(vy_reg); end
                    6'd5:    begin mul_a = 18'(vz_reg); mul_b = 21'(vx_reg); end
                    6'd6:    begin mul_a = 18'(w_reg);  mul_b = 21'(vz_reg); end
                    6'd7:    begin mul_a = 18'(vx_reg); mul_b = 21'(vy_reg); end
                    default: begin mul_a = 18'(vz_reg); mul_b = 21'(vz_reg); end
                endcase
            end
            S_SQ:
            begin
                case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = $signed({4'd0, s_abs[28:15]});
                        mul_b = $signed({7'd0, s_abs[28:15]});
                    end
                    6'd1:
                    begin
                        mul_a = $signed({4'd0, s_abs[28:15]});
                        mul_b = $signed({6'd0, s_abs[14:0]});
                    end
                    default:
                    begin
                        mul_a = $signed({3'd0, s_abs[14:0]});
                        mul_b = $signed({6'd0, s_abs[14:0]});
                    end
                endcase
            end
            S_CMUL:
            begin
                mul_a = err_reg;
                mul_b = $signed({5'd0, gain_reg});
            end
            default: ;
        endcase
    end

    assign mul_p = 39'(mul_a) * 39'(mul_b);

    // Pitch term, clamped to +-1.0 in Q28
    assign ps2   = {ps_reg, 1'b0};
    always_comb
    begin
        if (ps2 > 35'sd268435456)
            s_c = 30'sd268435456;
        else if (ps2 < -35'sd268435456)
            s_c = -30'sd268435456;
        else
            s_c = 30'(ps2);
        s_abs = s_c[29] ? 30'(-s_c) : 30'(s_c);
    end

    // CORDIC operands for roll, pitch, yaw
    always_comb
    begin
        case (sel_reg)
            2'd0:
            begin
                cy_in = 40'(ry_reg) <<< 1;
                cx_in = 40'sd268435456 - (40'(rx_reg) <<< 1);
            end
            2'd1:
            begin
                cy_in = 40'(s_c);
                cx_in = $signed(40'(sqr_reg[38:0]));
            end
            default:
            begin
                cy_in = 40'(yy_reg) <<< 1;
                cx_in = 40'sd268435456 - (40'(yx_reg) <<< 1);
            end
        endcase
    end

    assign zr   = rnd_shift(40'(cz_reg), 13);
    assign corr = rnd_shift(40'(prod_reg), 16);
    assign rb   = 59'(sqr_reg) + 59'(sqb_reg);
    assign rem2 = {rem_reg, dvd_reg[31]};

    // GPS validity and heading error
    always_comb
    begin
        gps_ok = fixv_reg && (fixt_reg != 32'd0) &&
                 (32'(now_reg - fixt_reg) < {16'd0, max_age_reg}) &&
                 (spd_reg >= min_speed_reg);
        course = (crs_reg >= 16'(FULL_TURN)) ? 17'(crs_reg - 16'(FULL_TURN))
                                             : 17'(crs_reg);
        e0 = $signed({1'b0, course}) - $signed({2'b0, yaw_reg});
        e1 = e0;
        if (e0 > 18'sd23040)
            e1 = e0 - 18'sd46080;
        if (e0 < -18'sd23040)
            e1 = e0 + 18'sd46080;
        past_db = (err_reg[17] ? 18'(-err_reg) : 18'(err_reg)) > {3'd0, deadband_reg};
        ys = $signed({2'b0, yaw_reg}) + 18'(corr);
    end

    // Sequencer, configuration, caches and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            sel_reg        <= '0;
            out_valid_reg  <= 1'b0;
            period_reg     <= 16'd20;
            max_age_reg    <= 16'd5000;
            min_speed_reg  <= 16'd500;
            full_scale_reg <= 16'd3000;
            gain_min_reg   <= 16'd3277;
            gain_max_reg   <= 16'd22938;
            deadband_reg   <= 15'd192;
            for (int i = 0; i < 3; i++)
            begin
                gyro_reg[i]  <= '0;
                accel_reg[i] <= '0;
            end
            last_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_PERIOD:     period_reg     <= cfg_data;
                    REG_MAX_AGE:    max_age_reg    <= cfg_data;
                    REG_MIN_SPEED:  min_speed_reg  <= cfg_data;
                    REG_FULL_SCALE: full_scale_reg <= cfg_data;
                    REG_GAIN_MIN:   gain_min_reg   <= cfg_data;
                    REG_GAIN_MAX:   gain_max_reg   <= cfg_data;
                    REG_DEADBAND:   deadband_reg   <= cfg_data[14:0];
                    default: ;
                endcase
            end

            // S_DONE reloads the output register itself
            if (out_ch.valid && out_ch.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    sel_reg <= '0;
                    if (in_fire)
                    begin
                        case (in_ch.action)
                            ACT_GYRO:  state_reg <= S_GYRO;
                            ACT_ACCEL:
                            begin
                                accel_reg[0] <= in_ch.val_x;
                                accel_reg[1] <= in_ch.val_y;
                                accel_reg[2] <= in_ch.val_z;
                            end
                            ACT_ROTV:
                            begin
                                if (due)
                                begin
                                    last_reg  <= in_ch.now_ms;
                                    state_reg <= S_PROD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_GYRO:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg != 6'd0)
                        gyro_reg[kd] <= 20'(rnd_shift(40'(prod_reg), 16));
                    if (cnt_reg == 6'd3)
                        state_reg <= S_IDLE;
                end
                S_PROD:
                begin
                    if (cnt_reg == 6'd9)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQ;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_SQ:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd3)
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sqb_reg[0])
                        state_reg <= S_CINIT;
                end
                S_CINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (cx_in == 40'sd0 && cy_in == 40'sd0) ? S_CDONE : S_CITER;
                end
                S_CITER:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CORDIC_STEPS - 1))
                        state_reg <= S_CDONE;
                end
                S_CDONE:
                begin
                    sel_reg   <= sel_reg + 2'd1;
                    state_reg <= (sel_reg == 2'd2) ? S_GPS : S_CINIT;
                end
                S_GPS:
                begin
                    cnt_reg   <= '0;
                    state_reg <= gps_ok ? S_DIV : S_DONE;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                        state_reg <= S_GAIN;
                end
                S_GAIN:  state_reg <= past_db ? S_CMUL : S_DONE;
                S_CMUL:  state_reg <= S_CORR;
                S_CORR:  state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Arithmetic datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (in_fire)
        begin
            vx_reg   <= in_ch.val_x;
            vy_reg   <= in_ch.val_y;
            vz_reg   <= in_ch.val_z;
            w_reg    <= in_ch.quat_w;
            acc_reg  <= in_ch.accuracy;
            now_reg  <= in_ch.now_ms;
            fixv_reg <= in_ch.gps_fix_valid;
            fixt_reg <= in_ch.gps_fix_time_ms;
            spd_reg  <= in_ch.gps_speed;
            crs_reg  <= in_ch.gps_course;
            ry_reg   <= '0;
            rx_reg   <= '0;
            ps_reg   <= '0;
            yy_reg   <= '0;
            yx_reg   <= '0;
            sq_reg   <= '0;
        end

        case (state_reg)
            // Accumulate quaternion products in the cycle after the multiply
            S_PROD:
            begin
                if (cnt_reg != 6'd0)
                begin
                    case (cnt_reg)
                        6'd1, 6'd2: ry_reg <= ry_reg + prod_reg[33:0];
                        6'd3:       rx_reg <= rx_reg + prod_reg[33:0];
                        6'd4:
                        begin
                            rx_reg <= rx_reg + prod_reg[33:0];
                            yx_reg <= yx_reg + prod_reg[33:0];
                        end
                        6'd5:       ps_reg <= ps_reg + prod_reg[33:0];
                        6'd6:       ps_reg <= ps_reg - prod_reg[33:0];
                        6'd7, 6'd8: yy_reg <= yy_reg + prod_reg[33:0];
                        default:    yx_reg <= yx_reg + prod_reg[33:0];
                    endcase
                end
            end
            // s^2 from three partial products
            S_SQ:
            begin
                case (cnt_reg)
                    6'd1:    sq_reg <= sq_reg + (58'(prod_reg[37:0]) << 30);
                    6'd2:    sq_reg <= sq_reg + (58'(prod_reg[37:0]) << 16);
                    6'd3:    sq_reg <= sq_reg + 58'(prod_reg[37:0]);
                    default: ;
                endcase
                sqr_reg <= '0;
                sqb_reg <= 58'd1 << 56;
                if (cnt_reg == 6'd3)
                    sqv_reg <= 57'(58'd1 << 56) - 57'(sq_reg + 58'(prod_reg[37:0]));
                else
                    sqv_reg <= 57'(58'd1 << 56) - sq_reg[56:0];
            end
            // Square root, one bit pair per cycle
            S_SQRT:
            begin
                if ({2'b0, sqv_reg} >= rb)
                begin
                    sqv_reg <= sqv_reg - rb[56:0];
                    sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                end
                else
                    sqr_reg <= sqr_reg >> 1;
                sqb_reg <= sqb_reg >> 2;
            end
            // CORDIC start: fold left half plane
            S_CINIT:
            begin
                if (cx_in < 40'sd0)
                begin
                    cz_reg <= (cy_in >= 40'sd0) ? 32'sd188743680 : -32'sd188743680;
                    cx_reg <= -cx_in;
                    cy_reg <= -cy_in;
                end
                else
                begin
                    cz_reg <= '0;
                    cx_reg <= cx_in;
                    cy_reg <= cy_in;
                end
            end
            // One vectoring iteration
            S_CITER:
            begin
                if (cy_reg > 40'sd0)
                begin
                    cx_reg <= cx_reg + (cy_reg >>> cidx);
                    cy_reg <= cy_reg - (cx_reg >>> cidx);
                    cz_reg <= cz_reg + $signed({5'd0, ATAN_TAB[cnt_reg[4:0]]});
                end
                else
                begin
                    cx_reg <= cx_reg - (cy_reg >>> cidx);
                    cy_reg <= cy_reg + (cx_reg >>> cidx);
                    cz_reg <= cz_reg - $signed({5'd0, ATAN_TAB[cnt_reg[4:0]]});
                end
            end
            // Round and range-guard the angle
            S_CDONE:
            begin
                case (sel_reg)
                    2'd0:
                    begin
                        if (zr > 40'sd23040)
                            roll_reg <= 16'sd23040;
                        else if (zr < -40'sd23040)
                            roll_reg <= -16'sd23040;
                        else
                            roll_reg <= 16'(zr);
                    end
                    2'd1:
                    begin
                        if (zr > 40'sd11520)
                            pitch_reg <= 15'sd11520;
                        else if (zr < -40'sd11520)
                            pitch_reg <= -15'sd11520;
                        else
                            pitch_reg <= 15'(zr);
                    end
                    default:
                    begin
                        if (zr > 40'sd23040)
                            yaw_reg <= 16'(HALF_TURN);
                        else if (zr < -40'sd23040)
                            yaw_reg <= 16'(HALF_TURN);
                        else if (zr < 40'sd0)
                            yaw_reg <= 16'(zr + 40'sd46080);
                        else
                            yaw_reg <= 16'(zr);
                    end
                endcase
            end
            S_GPS:
            begin
                err_reg <= e1;
                rem_reg <= '0;
                quo_reg <= '0;
                dvd_reg <= {spd_reg, 16'd0};
            end
            // Restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                if (rem2 >= {2'b0, full_scale_reg})
                begin
                    rem_reg <= 17'(rem2 - {2'b0, full_scale_reg});
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[16:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                dvd_reg <= dvd_reg << 1;
            end
            S_GAIN:
            begin
                if (quo_reg < {16'd0, gain_min_reg})
                    gain_reg <= gain_min_reg;
                else if (quo_reg > {16'd0, gain_max_reg})
                    gain_reg <= gain_max_reg;
                else
                    gain_reg <= quo_reg[15:0];
            end
            S_CORR:
            begin
                if (ys < 18'sd0)
                    yaw_reg <= 16'(ys + 18'sd46080);
                else if (ys >= 18'sd46080)
                    yaw_reg <= 16'(ys - 18'sd46080);
                else
                    yaw_reg <= 16'(ys);
            end
            default: ;
        endcase

        // Load the packet into the output register
        if (state_reg == S_DONE && out_free)
        begin
            o_roll_reg  <= roll_reg;
            o_pitch_reg <= pitch_reg;
            o_yaw_reg   <= yaw_reg;
            o_acc_reg   <= acc_reg;
            o_stamp_reg <= now_reg;
            for (int i = 0; i < 3; i++)
            begin
                o_gyro_reg[i]  <= gyro_reg[i];
                o_accel_reg[i] <= accel_reg[i];
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.roll         = o_roll_reg;
    assign out_ch.pitch        = o_pitch_reg;
    assign out_ch.yaw          = o_yaw_reg;
    assign out_ch.gyro_x       = o_gyro_reg[0];
    assign out_ch.gyro_y       = o_gyro_reg[1];
    assign out_ch.gyro_z       = o_gyro_reg[2];
    assign out_ch.accel_x      = o_accel_reg[0];
    assign out_ch.accel_y      = o_accel_reg[1];
    assign out_ch.accel_z      = o_accel_reg[2];
    assign out_ch.accuracy_out = o_acc_reg;
    assign out_ch.stamp_ms     = o_stamp_reg;

endmodule
